[rtl/cpte_pkg.sv]
// Shared types, register indexes and encoding constants for the code point encoder.
// No dependencies; every other file in rtl imports this package.
package cpte_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENCODING_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRLF_ENABLE   = 1'd1;

  // Encoding modes; the unused code behaves as UTF-16 big-endian.
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_UTF8   = 2'd1;
  localparam logic [1:0] MODE_UTF16  = 2'd2;

  // Character constants.
  localparam logic [31:0] NL_CODE   = 32'h0000_000A;
  localparam logic [7:0]  CR_BYTE   = 8'd13;
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // Default depth of the queue between front and back.
  localparam int unsigned CPTE_QUEUE_DEPTH = 2;

  // One encoded run: up to four bytes, byte 0 first, and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } cpte_entry_t;

endpackage

[rtl/cpte_front.sv]
// Front end of the code point encoder: configuration registers, request
// acceptance and classification of each code point into a run of bytes.
// Depends on cpte_pkg.
module cpte_front import cpte_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            code_point,
  input  logic                   queue_full,
  output logic                   push,
  output cpte_entry_t            push_entry
);

  logic [1:0]  encoding_mode;
  logic        crlf_enable;
  logic        cr;
  logic        utf16_bmp;
  logic        utf16_supp;
  logic [19:0] supp_offset;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= MODE_UTF8;
      crlf_enable   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENCODING_MODE: encoding_mode <= cfg_data;
        REG_CRLF_ENABLE:   crlf_enable   <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // A request is taken whenever the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Newline test used by every mode, and range tests for the UTF-16 path.
  assign cr          = crlf_enable && (code_point == NL_CODE);
  assign utf16_bmp   = (code_point[31:16] == 16'h0000);
  assign utf16_supp  = (code_point[31:16] <= 16'h0010);
  assign supp_offset = code_point[19:0] - 20'h1_0000;

  // Classification into the byte run.
  always_comb begin
    push_entry = '0;
    unique case (encoding_mode)
      MODE_SINGLE: begin
        if (cr) begin
          push_entry.bytes[0] = CR_BYTE;
          push_entry.bytes[1] = code_point[7:0];
          push_entry.last_idx = 2'd1;
        end else begin
          push_entry.bytes[0] = code_point[7:0];
          push_entry.last_idx = 2'd0;
        end
      end
      MODE_UTF8: begin
        if (code_point[31:7] == 25'd0) begin
          // Only the one-byte path carries the carriage return.
          if (cr) begin
            push_entry.bytes[0] = CR_BYTE;
            push_entry.bytes[1] = code_point[7:0];
            push_entry.last_idx = 2'd1;
          end else begin
            push_entry.bytes[0] = code_point[7:0];
            push_entry.last_idx = 2'd0;
          end
        end else if (code_point[31:11] == 21'd0) begin
          push_entry.bytes[0] = {3'b110, code_point[10:6]};
          push_entry.bytes[1] = {2'b10, code_point[5:0]};
          push_entry.last_idx = 2'd1;
        end else if (code_point[31:16] == 16'd0) begin
          push_entry.bytes[0] = {4'hE, code_point[15:12]};
          push_entry.bytes[1] = {2'b10, code_point[11:6]};
          push_entry.bytes[2] = {2'b10, code_point[5:0]};
          push_entry.last_idx = 2'd2;
        end else begin
          // Four-byte form; the lead byte keeps only bits 21:18 above the marker.
          push_entry.bytes[0] = {4'hF, code_point[21:18]};
          push_entry.bytes[1] = {2'b10, code_point[17:12]};
          push_entry.bytes[2] = {2'b10, code_point[11:6]};
          push_entry.bytes[3] = {2'b10, code_point[5:0]};
          push_entry.last_idx = 2'd3;
        end
      end
      default: begin
        // UTF-16 big-endian, also used for the unused mode code.
        if (cr) begin
          push_entry.bytes[0] = 8'h00;
          push_entry.bytes[1] = CR_BYTE;
          push_entry.bytes[2] = code_point[15:8];
          push_entry.bytes[3] = code_point[7:0];
          push_entry.last_idx = 2'd3;
        end else if (utf16_bmp) begin
          push_entry.bytes[0] = code_point[15:8];
          push_entry.bytes[1] = code_point[7:0];
          push_entry.last_idx = 2'd1;
        end else if (utf16_supp) begin
          push_entry.bytes[0] = {6'b110110, supp_offset[19:18]};
          push_entry.bytes[1] = supp_offset[17:10];
          push_entry.bytes[2] = {6'b110111, supp_offset[9:8]};
          push_entry.bytes[3] = supp_offset[7:0];
          push_entry.last_idx = 2'd3;
        end else begin
          push_entry.bytes[0] = REPL_UNIT[15:8];
          push_entry.bytes[1] = REPL_UNIT[7:0];
          push_entry.last_idx = 2'd1;
        end
      end
    endcase
  end

endmodule

[rtl/cpte_queue.sv]
// Small queue of encoded runs between the front and back of the encoder.
// Depends on cpte_pkg for the entry type.
module cpte_queue import cpte_pkg::*; #(
  parameter int unsigned DEPTH = CPTE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cpte_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output cpte_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cpte_entry_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/cpte_back.sv]
// Back end of the encoder: walks the head run of the queue and sends one
// byte per request through a registered output. Depends on cpte_pkg.
module cpte_back import cpte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cpte_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic [1:0] byte_idx;
  logic       load;
  logic       at_last;

  // The output register takes a new byte when it is empty or being drained.
  assign load    = head_valid && (!out_valid || !out_stall);
  assign at_last = (byte_idx == head.last_idx);
  assign pop     = load && at_last;

  // Control: output valid and position within the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      byte_idx  <= at_last ? 2'd0 : byte_idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= head.bytes[byte_idx];
      last_byte <= at_last;
    end
  end

endmodule

[rtl/code_point_text_encoder.sv]
// Code point text encoder, top level: front end, run queue and byte sender.
// Depends on cpte_pkg, cpte_front, cpte_queue and cpte_back.
//
// Usage:
//   Input channel: code_point with in_valid / in_stall; a request is taken at
//   a rising edge with in_valid high and in_stall low.
//   Output channel: out_byte and last_byte with out_valid / out_stall; one
//   byte per request, last_byte marks the final byte of a code point's run.
//   Configuration: cfg_write, cfg_index, cfg_data; index 0 is the encoding
//   mode (0 single byte, 1 UTF-8, 2 UTF-16 BE), index 1 the CRLF enable.
//   Write configuration only while no run is in flight.
// Timing:
//   The first byte of a code point passes through the queue and then the
//   output register before it is valid. The output register sends one byte
//   per cycle while a run waits and out_stall is low; a code point's run is
//   1 to 4 bytes, and that single-byte output path sets the sustained rate.
//   The queue of QUEUE_DEPTH runs lets requests be taken while earlier bytes
//   wait; in_stall rises only when the queue is full.
// Reset:
//   Synchronous reset empties the queue, drops out_valid and sets the mode
//   to UTF-8 with CRLF off. A stalled output byte holds until taken.
module code_point_text_encoder import cpte_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = CPTE_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            code_point,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   last_byte
);

  logic        push;
  cpte_entry_t push_entry;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  cpte_entry_t head;

  // Classification of incoming code points.
  cpte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Runs waiting for the back end.
  cpte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Byte-by-byte output.
  cpte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

endmodule

[rtl/cpte_checker.sv]
// Port-level checks for the code point encoder, bound to the top level.
// Depends on cpte_pkg and code_point_text_encoder.
module cpte_checker import cpte_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last_byte
);

  logic       in_take;
  logic       out_take;
  logic [7:0] pending;
  logic [2:0] run_len;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Code points taken whose last byte has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, in_take} - {7'd0, out_take && last_byte};
    end
  end

  // Bytes already delivered in the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= '0;
    end else if (out_take) begin
      run_len <= last_byte ? 3'd0 : run_len + 3'd1;
    end
  end

  // A stalled byte holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("stalled output byte changed");

  // Reset leaves no byte on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // No run is longer than four bytes.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (run_len == 3'd3) |-> last_byte)
    else $error("run longer than four bytes");

  // Every byte belongs to a code point that was taken.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 8'd0))
    else $error("output byte without a pending code point");

endmodule

bind code_point_text_encoder cpte_checker u_cpte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);
